/* hw/rtl/chdec_pkg.sv */
// Package for the chunked body decoder: transaction structs, parser phase
// and status enums, character constants and the hex digit decode function.
// No dependencies.
package chdec_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int BODY_LENGTH_BITS    = 32;

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   typedef enum logic [3:0] {
      PH_START     = 4'd0,
      PH_SIZE      = 4'd1,
      PH_EXT       = 4'd2,
      PH_EXT_LF    = 4'd3,
      PH_DATA      = 4'd4,
      PH_DATA_CR   = 4'd5,
      PH_DATA_LF   = 4'd6,
      PH_TRL_START = 4'd7,
      PH_TRL       = 4'd8,
      PH_TRL_LF    = 4'd9,
      PH_END_LF    = 4'd10,
      PH_DONE      = 4'd11,
      PH_ERROR     = 4'd12
   } phase_type;

   typedef enum logic [1:0] {
      ST_BUSY  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]                  data_byte;
      logic                        data_valid;
      status_type                  status;
      logic [BODY_LENGTH_BITS-1:0] body_length;
   } rsp_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   // Decodes an ASCII hex digit in either letter case.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.is_hex = 1'b0;
      h.value  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.is_hex = 1'b1;
         h.value  = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.is_hex = 1'b1;
         h.value  = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

/* hw/rtl/chdec_core.sv */
// Parser core of the chunked body decoder: phase, chunk count and body total
// registers with their next-state logic. Depends on chdec_pkg.
module chdec_core #(
   parameter int LENGTH_BITS = chdec_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  chdec_pkg::req_type item,
   output chdec_pkg::rsp_type result
);

   chdec_pkg::phase_type   phase_ff, phase_in, phase_cur, line_phase;
   logic [LENGTH_BITS-1:0] chunk_ff, chunk_in, chunk_cur;
   logic [LENGTH_BITS-1:0] body_ff, body_in, body_cur;
   logic [LENGTH_BITS:0]   sum;
   chdec_pkg::hex_type     hex;
   logic [7:0]             c;

   // A first byte clears the parser before the byte itself is parsed.
   assign c         = item.in_byte;
   assign hex       = chdec_pkg::hex_decode(c);
   assign phase_cur = item.first_byte ? chdec_pkg::PH_START : phase_ff;
   assign chunk_cur = item.first_byte ? '0 : chunk_ff;
   assign body_cur  = item.first_byte ? '0 : body_ff;

   // End of a size line: a zero size opens the trailer, and a size that would
   // carry the body total out of range is an error.
   assign sum = {1'b0, chunk_cur} + {1'b0, body_cur};
   always_comb begin
      if (chunk_cur == '0) begin
         line_phase = chdec_pkg::PH_TRL_START;
      end else if (sum[LENGTH_BITS]) begin
         line_phase = chdec_pkg::PH_ERROR;
      end else begin
         line_phase = chdec_pkg::PH_DATA;
      end
   end

   always_comb begin
      phase_in = phase_cur;
      chunk_in = chunk_cur;
      body_in  = body_cur;
      case (phase_cur)
         chdec_pkg::PH_START: begin
            if (hex.is_hex) begin
               chunk_in = LENGTH_BITS'(hex.value);
               phase_in = chdec_pkg::PH_SIZE;
            end else begin
               phase_in = chdec_pkg::PH_ERROR;
            end
         end
         chdec_pkg::PH_SIZE: begin
            if (hex.is_hex) begin
               // A nonzero top digit means one more digit would overflow.
               if (chunk_cur[LENGTH_BITS-1 -: 4] != 4'd0) begin
                  phase_in = chdec_pkg::PH_ERROR;
               end else begin
                  chunk_in = {chunk_cur[LENGTH_BITS-5:0], hex.value};
               end
            end else if (c == chdec_pkg::CH_TAB || c == chdec_pkg::CH_SP ||
                         c == chdec_pkg::CH_SEMI) begin
               phase_in = chdec_pkg::PH_EXT;
            end else if (c == chdec_pkg::CH_CR) begin
               phase_in = chdec_pkg::PH_EXT_LF;
            end else if (c == chdec_pkg::CH_LF) begin
               phase_in = line_phase;
            end else begin
               phase_in = chdec_pkg::PH_ERROR;
            end
         end
         chdec_pkg::PH_EXT: begin
            if (c == chdec_pkg::CH_CR) begin
               phase_in = chdec_pkg::PH_EXT_LF;
            end else if (c == chdec_pkg::CH_LF) begin
               phase_in = line_phase;
            end
         end
         chdec_pkg::PH_EXT_LF: begin
            phase_in = (c == chdec_pkg::CH_LF) ? line_phase : chdec_pkg::PH_ERROR;
         end
         chdec_pkg::PH_DATA: begin
            body_in  = body_cur + LENGTH_BITS'(1);
            chunk_in = chunk_cur - LENGTH_BITS'(1);
            if (chunk_cur == LENGTH_BITS'(1)) begin
               phase_in = chdec_pkg::PH_DATA_CR;
            end
         end
         chdec_pkg::PH_DATA_CR: begin
            phase_in = (c == chdec_pkg::CH_CR) ? chdec_pkg::PH_DATA_LF :
                                                 chdec_pkg::PH_ERROR;
         end
         chdec_pkg::PH_DATA_LF: begin
            if (c == chdec_pkg::CH_LF) begin
               phase_in = chdec_pkg::PH_START;
               chunk_in = '0;
            end else begin
               phase_in = chdec_pkg::PH_ERROR;
            end
         end
         chdec_pkg::PH_TRL_START: begin
            if (c == chdec_pkg::CH_CR) begin
               phase_in = chdec_pkg::PH_END_LF;
            end else if (c == chdec_pkg::CH_LF) begin
               phase_in = chdec_pkg::PH_DONE;
            end else begin
               phase_in = chdec_pkg::PH_TRL;
            end
         end
         chdec_pkg::PH_TRL: begin
            if (c == chdec_pkg::CH_CR) begin
               phase_in = chdec_pkg::PH_TRL_LF;
            end else if (c == chdec_pkg::CH_LF) begin
               phase_in = chdec_pkg::PH_TRL_START;
            end
         end
         chdec_pkg::PH_TRL_LF: begin
            phase_in = (c == chdec_pkg::CH_LF) ? chdec_pkg::PH_TRL_START :
                                                 chdec_pkg::PH_ERROR;
         end
         chdec_pkg::PH_END_LF: begin
            phase_in = (c == chdec_pkg::CH_LF) ? chdec_pkg::PH_DONE :
                                                 chdec_pkg::PH_ERROR;
         end
         chdec_pkg::PH_DONE: begin
            phase_in = chdec_pkg::PH_DONE;
         end
         default: begin
            phase_in = chdec_pkg::PH_ERROR;
         end
      endcase
   end

   always_comb begin
      result.data_valid  = (phase_cur == chdec_pkg::PH_DATA);
      result.data_byte   = result.data_valid ? c : 8'd0;
      result.body_length = chdec_pkg::BODY_LENGTH_BITS'(body_in);
      case (phase_in)
         chdec_pkg::PH_DONE:  result.status = chdec_pkg::ST_DONE;
         chdec_pkg::PH_ERROR: result.status = chdec_pkg::ST_ERROR;
         default:             result.status = chdec_pkg::ST_BUSY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= chdec_pkg::PH_START;
         chunk_ff <= '0;
         body_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         chunk_ff <= chunk_in;
         body_ff  <= body_in;
      end
   end

   // Payload bytes only ever leave from the data phase with a count left.
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == chdec_pkg::PH_DATA) |-> (chunk_ff != '0))
      else $error("data phase with no payload bytes left");

   // Each payload byte advances the body total by exactly one.
   a_body_step: assert property (@(posedge clock) disable iff (reset)
      (step && result.data_valid) |=> (body_ff == $past(body_cur) + LENGTH_BITS'(1)))
      else $error("body total did not advance with a payload byte");

   // Terminal phases are left only by a first byte; this check covers the done phase.
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == chdec_pkg::PH_DONE && step && !item.first_byte) |=>
      (phase_ff == chdec_pkg::PH_DONE))
      else $error("left the done phase without a first byte");

endmodule

/* hw/rtl/http_chunked_body_decoder.sv */
// Top level of the chunked HTTP body decoder: input register, parser core and
// result register with valid/stall handshakes. Depends on chdec_pkg, chdec_core.
//
//   Channel | Ports                          | Direction | Payload
//   --------+--------------------------------+-----------+-------------------------
//   request | req_valid, req_stall, req_data | in        | chdec_pkg::req_type
//   result  | rsp_valid, rsp_stall, rsp_data | out       | chdec_pkg::rsp_type
//
// Every request transaction yields exactly one result transaction. One byte
// is taken each cycle unless the result side stalls; that rate is set by the
// parser state update, a single pass of phase, chunk count and body total
// logic between the input and result registers. Reset is synchronous and
// active high; it empties both registers and returns the parser to the start
// of a chunk. A stall on the result side holds the result register and backs
// up into the input register, which then stalls the request side.
//
// The decoder reads hex chunk sizes, skips extensions and trailer lines, and
// passes payload bytes through with a running body length. Status reports
// completion after the final empty line, or an error on malformed input or a
// size or body total that does not fit in LENGTH_BITS bits. After completion
// or an error, bytes are ignored until a byte that carries first_byte.
module http_chunked_body_decoder #(
   parameter int LENGTH_BITS = chdec_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  chdec_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output chdec_pkg::rsp_type rsp_data
);

   logic               req_valid_ff, req_valid_in;
   chdec_pkg::req_type req_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   chdec_pkg::rsp_type rsp_ff;
   chdec_pkg::rsp_type core_rsp;
   logic               advance;

   // The held byte moves to the result register whenever that register is
   // empty or its transaction is being taken in the same cycle.
   assign advance   = req_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   chdec_core #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_ff),
      .result (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A payload byte can only appear while the message is still in progress.
   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.data_valid) |-> (rsp_data.status == chdec_pkg::ST_BUSY))
      else $error("payload byte reported with a final status");

   // The request side is stalled only while a byte is held and blocked.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked result");

   // A transaction held in the input register is never dropped.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> req_valid_ff)
      else $error("held request transaction was lost");

   // Nothing is offered on the result side right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
